>>> rtl/ptw_pkg.sv
// ptw_pkg: shared types and constants for the four-level page table walker.
// Used by ptw_step and four_level_page_table_walker; no dependencies.
package ptw_pkg;

    localparam int PHYS_MASK_BITS_DEF = 36;
    localparam int ADDR_W = 52;
    localparam int VA_W   = 48;
    localparam int DATA_W = 64;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic ACT_REQUEST  = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;

    typedef enum logic [2:0] {
        LVL_IDLE = 3'd0,
        LVL_1    = 3'd1,
        LVL_2    = 3'd2,
        LVL_3    = 3'd3,
        LVL_4    = 3'd4
    } level_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic              fault;
    } result_t;

    typedef struct packed {
        logic    has_result;
        result_t res;
        level_t  level_next;
        logic    load_vaddr;
    } step_t;

endpackage

>>> rtl/ptw_step.sv
// ptw_step: one walk step for a request or read-response beat.
// Depends on ptw_pkg.
module ptw_step
    import ptw_pkg::*;
#(
    parameter int PHYS_MASK_BITS = PHYS_MASK_BITS_DEF
) (
    input  level_t            level,
    input  logic [VA_W-1:0]   saved_vaddr,
    input  logic              action,
    input  logic [ADDR_W-1:0] table_base,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [DATA_W-1:0] read_data,
    output step_t             step
);

    localparam logic [ADDR_W-1:0] PMASK =
        ((ADDR_W'(1) << PHYS_MASK_BITS) - ADDR_W'(1)) & ~ADDR_W'(12'hFFF);

    logic [ADDR_W-1:0] entry_base;
    logic [ADDR_W-1:0] req_addr;
    logic              present;
    logic              page_size;

    assign entry_base = read_data[ADDR_W-1:0] & PMASK;
    assign present    = read_data[PRESENT_BIT];
    assign page_size  = read_data[LARGE_BIT];
    assign req_addr   = (table_base & ~ADDR_W'(4'hF))
                      + {40'd0, virt_addr[47:39], 3'd0};

    always_comb begin
        step.has_result  = 1'b0;
        step.res.kind    = KIND_READ;
        step.res.address = '0;
        step.res.fault   = 1'b0;
        step.level_next  = level;
        step.load_vaddr  = 1'b0;
        if (action == ACT_REQUEST) begin
            if (level == LVL_IDLE) begin
                step.has_result  = 1'b1;
                step.res.address = req_addr;
                step.level_next  = LVL_1;
                step.load_vaddr  = 1'b1;
            end
        end else begin
            unique case (level)
                LVL_1: begin
                    step.has_result = 1'b1;
                    if (!present) begin
                        step.res.kind   = KIND_FINISH;
                        step.res.fault  = 1'b1;
                        step.level_next = LVL_IDLE;
                    end else begin
                        step.res.address = entry_base + {40'd0, saved_vaddr[38:30], 3'd0};
                        step.level_next  = LVL_2;
                    end
                end
                LVL_2: begin
                    step.has_result = 1'b1;
                    if (!present) begin
                        step.res.kind   = KIND_FINISH;
                        step.res.fault  = 1'b1;
                        step.level_next = LVL_IDLE;
                    end else if (page_size) begin
                        step.res.kind    = KIND_FINISH;
                        step.res.address = {read_data[51:30], saved_vaddr[29:0]};
                        step.level_next  = LVL_IDLE;
                    end else begin
                        step.res.address = entry_base + {40'd0, saved_vaddr[29:21], 3'd0};
                        step.level_next  = LVL_3;
                    end
                end
                LVL_3: begin
                    step.has_result = 1'b1;
                    if (!present) begin
                        step.res.kind   = KIND_FINISH;
                        step.res.fault  = 1'b1;
                        step.level_next = LVL_IDLE;
                    end else if (page_size) begin
                        step.res.kind    = KIND_FINISH;
                        step.res.address = entry_base + {31'd0, saved_vaddr[20:0]};
                        step.level_next  = LVL_IDLE;
                    end else begin
                        step.res.address = entry_base + {40'd0, saved_vaddr[20:12], 3'd0};
                        step.level_next  = LVL_4;
                    end
                end
                LVL_4: begin
                    step.has_result = 1'b1;
                    step.res.kind   = KIND_FINISH;
                    step.level_next = LVL_IDLE;
                    if (entry_base == '0) begin
                        step.res.fault = 1'b1;
                    end else begin
                        step.res.address = entry_base + {40'd0, saved_vaddr[11:0]};
                    end
                end
                default: begin
                    step.level_next = LVL_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/four_level_page_table_walker.sv
// four_level_page_table_walker: top level, walk state and output buffering.
// Depends on ptw_pkg and ptw_step.
//
// Usage: the s_ channel carries request beats (action 0: table_base,
// virt_addr) and memory read-response beats (action 1: read_data). The m_
// channel carries read requests (kind 0, entry address) and finished
// translations (kind 1, physical address, fault).
// Each input beat is decoded in the cycle it is accepted by ptw_step and its
// result is registered; one beat is taken per cycle while s_ready is high.
// A request during a walk and a response while idle are dropped silently.
// The output has a main register plus a one-entry skid, so a beat is still
// taken while a result waits; s_ready falls only when both are full, and a
// stalled receiver holds m_ at their values until taken.
// Reset (aresetn low, synchronous) empties both output stages and returns
// the walk to idle.
module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int PHYS_MASK_BITS = PHYS_MASK_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [ADDR_W-1:0] s_table_base,
    input  logic [VA_W-1:0]   s_virt_addr,
    input  logic [DATA_W-1:0] s_read_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [ADDR_W-1:0] m_address,
    output logic              m_fault
);

    level_t          level_reg;
    logic [VA_W-1:0] vaddr_reg;
    step_t           step;
    logic            main_valid_reg;
    result_t         main_reg;
    logic            skid_valid_reg;
    result_t         skid_reg;
    logic            accept;
    logic            push;
    logic            pop;

    ptw_step #(
        .PHYS_MASK_BITS(PHYS_MASK_BITS)
    ) u_step (
        .level      (level_reg),
        .saved_vaddr(vaddr_reg),
        .action     (s_action),
        .table_base (s_table_base),
        .virt_addr  (s_virt_addr),
        .read_data  (s_read_data),
        .step       (step)
    );

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign push      = accept && step.has_result;
    assign pop       = main_valid_reg && m_ready;
    assign m_valid   = main_valid_reg;
    assign m_kind    = main_reg.kind;
    assign m_address = main_reg.address;
    assign m_fault   = main_reg.fault;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LVL_IDLE;
            vaddr_reg <= '0;
        end else if (accept) begin
            level_reg <= step.level_next;
            if (step.load_vaddr) begin
                vaddr_reg <= s_virt_addr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (main_valid_reg && !pop) begin
            if (push) begin
                skid_reg       <= step.res;
                skid_valid_reg <= 1'b1;
            end
        end else begin
            main_valid_reg <= push;
            if (push) begin
                main_reg <= step.res;
            end
        end
    end

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds a beat while main stage is empty");

    a_fault_is_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault) |-> (m_kind == KIND_FINISH && m_address == '0))
        else $error("fault beat not a zero-address finish");

    a_finish_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && step.res.kind == KIND_FINISH) |=> (level_reg == LVL_IDLE))
        else $error("walk not idle after finish");

    a_request_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ACT_REQUEST && level_reg == LVL_IDLE)
        |=> (level_reg == LVL_1 && vaddr_reg == $past(s_virt_addr)))
        else $error("request did not start walk");

    a_idle_response_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ACT_RESPONSE && level_reg == LVL_IDLE) |-> !push)
        else $error("response while idle produced a result");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for four_level_page_table_walker: directed walks, then
// random well-formed page walks mixed with stray beats. Depends on ptw_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ptw_pkg::*;

    localparam int PMB = PHYS_MASK_BITS_DEF;
    localparam logic [ADDR_W-1:0] PMASK = ((52'd1 << PMB) - 52'd1) & ~52'hFFF;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_BEATS = 800;
    localparam int HOLD_CYCLES = 64;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic [ADDR_W-1:0] s_table_base;
    logic [VA_W-1:0]   s_virt_addr;
    logic [DATA_W-1:0] s_read_data;
    logic              m_valid;
    logic              m_ready;
    logic              m_kind;
    logic [ADDR_W-1:0] m_address;
    logic              m_fault;

    bit idle_on;
    bit hold_req;
    int cycles;

    four_level_page_table_walker #(.PHYS_MASK_BITS(PMB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_table_base(s_table_base), .s_virt_addr(s_virt_addr), .s_read_data(s_read_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_address(m_address), .m_fault(m_fault)
    );

    class walk_tracker;
        level_t            level;
        logic [VA_W-1:0]   vaddr;
        result_t           pending_results[$];
        int                errors;
        int                n_beats, n_ignored, n_reads, n_done, n_faults;

        function new();
            level = LVL_IDLE;
            vaddr = '0;
            errors = 0;
            n_beats = 0;
            n_ignored = 0;
            n_reads = 0;
            n_done = 0;
            n_faults = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void push(logic kind, logic [ADDR_W-1:0] addr, logic flt);
            result_t r;
            r.kind = kind;
            r.address = addr;
            r.fault = flt;
            pending_results.push_back(r);
            if (kind == KIND_FINISH) begin
                level = LVL_IDLE;
            end
        endfunction

        function void next_read(logic [DATA_W-1:0] data, logic [8:0] idx, level_t nxt);
            level = nxt;
            push(KIND_READ, (data[ADDR_W-1:0] & PMASK) + {40'd0, idx, 3'd0}, 1'b0);
        endfunction

        function void predict_walk_step(logic act, logic [ADDR_W-1:0] base,
                                        logic [VA_W-1:0] va, logic [DATA_W-1:0] data);
            logic [ADDR_W-1:0] leaf;
            n_beats++;
            if (act == ACT_REQUEST) begin
                if (level != LVL_IDLE) begin
                    n_ignored++;
                end else begin
                    vaddr = va;
                    level = LVL_1;
                    push(KIND_READ, {base[ADDR_W-1:4], 4'd0} + {40'd0, va[47:39], 3'd0}, 1'b0);
                end
            end else begin
                case (level)
                    LVL_1: begin
                        if (!data[PRESENT_BIT]) push(KIND_FINISH, '0, 1'b1);
                        else next_read(data, vaddr[38:30], LVL_2);
                    end
                    LVL_2: begin
                        if (!data[PRESENT_BIT]) push(KIND_FINISH, '0, 1'b1);
                        else if (data[LARGE_BIT])
                            push(KIND_FINISH, {data[51:30], vaddr[29:0]}, 1'b0);
                        else next_read(data, vaddr[29:21], LVL_3);
                    end
                    LVL_3: begin
                        if (!data[PRESENT_BIT]) push(KIND_FINISH, '0, 1'b1);
                        else if (data[LARGE_BIT])
                            push(KIND_FINISH, (data[ADDR_W-1:0] & PMASK) + {31'd0, vaddr[20:0]},
                                 1'b0);
                        else next_read(data, vaddr[20:12], LVL_4);
                    end
                    LVL_4: begin
                        leaf = data[ADDR_W-1:0] & PMASK;
                        if (leaf == '0) push(KIND_FINISH, '0, 1'b1);
                        else push(KIND_FINISH, leaf + {40'd0, vaddr[11:0]}, 1'b0);
                    end
                    default: begin
                        n_ignored++;
                        level = LVL_IDLE;
                    end
                endcase
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30) begin
                $display("ERROR @%0t: %s", $time, msg);
            end
        endtask

        task check_result(logic kind, logic [ADDR_W-1:0] addr, logic flt);
            result_t e;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind=%0b address=%h fault=%0b",
                                          kind, addr, flt));
                return;
            end
            e = pending_results.pop_front();
            if (e.kind == KIND_READ) n_reads++;
            else if (e.fault) n_faults++;
            else n_done++;
            if (kind !== e.kind)
                report_mismatch($sformatf("kind %0b, expected %0b", kind, e.kind));
            if (addr !== e.address)
                report_mismatch($sformatf("address %h, expected %h", addr, e.address));
            if (flt !== e.fault)
                report_mismatch($sformatf("fault %0b, expected %0b", flt, e.fault));
        endtask
    endclass

    walk_tracker walk;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            walk.predict_walk_step(s_action, s_table_base, s_virt_addr, s_read_data);
        if (aresetn && m_valid && m_ready)
            walk.check_result(m_kind, m_address, m_fault);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
            end
            m_ready = !(idle_on && $urandom_range(0, 99) < 34);
        end
    end

    // called and returns at a falling edge; valid stays high on return
    task drive_beat(logic act, logic [ADDR_W-1:0] base, logic [VA_W-1:0] va,
                    logic [DATA_W-1:0] data);
        while (idle_on && $urandom_range(0, 99) < 34) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = act;
        s_table_base = base;
        s_virt_addr = va;
        s_read_data = data;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task send_request(logic [ADDR_W-1:0] base, logic [VA_W-1:0] va);
        drive_beat(ACT_REQUEST, base, va, {$urandom, $urandom});
    endtask

    task send_entry(logic [DATA_W-1:0] data);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        drive_beat(ACT_RESPONSE, junk[ADDR_W-1:0], junk[VA_W-1:0], data);
    endtask

    task wait_drained();
        s_valid = 1'b0;
        while (walk.outstanding() != 0) @(negedge aclk);
    endtask

    function logic [DATA_W-1:0] random_entry(level_t lvl);
        logic [DATA_W-1:0] d;
        d = {$urandom, $urandom};
        d[PRESENT_BIT] = ($urandom_range(0, 99) >= 10);
        if (lvl == LVL_2 || lvl == LVL_3) d[LARGE_BIT] = ($urandom_range(0, 99) < 25);
        if (lvl == LVL_4 && $urandom_range(0, 99) < 10) d = d & ~{12'd0, PMASK};
        return d;
    endfunction

    initial begin
        logic [63:0] r1, r2;
        logic [DATA_W-1:0] nonlarge;
        int n_items;
        bit hold_done, pause_done;

        walk = new();
        idle_on = 1'b1;
        hold_req = 1'b0;
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_REQUEST;
        s_table_base = '0;
        s_virt_addr = '0;
        s_read_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        nonlarge = 64'hFFFF_FFFF_FFFF_FF7F;
        // address wrap, then a top-level fault
        send_request('1, '1);
        send_entry(64'h0);
        // stray response while idle
        send_entry('1);
        // stray request mid-walk; zero translation through a 1 GiB page
        send_request('0, '0);
        send_request('1, '1);
        send_entry(64'h1);
        send_entry(64'h81);
        // 2 MiB page
        send_request(52'h0_0123_4567_89AB, 48'hFEDC_BA98_7654);
        send_entry('1);
        send_entry(nonlarge);
        send_entry('1);
        // second-level fault
        send_request(52'hA_5A5A_5A5A_5A5F, 48'h5555_5555_5555);
        send_entry('1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFE);
        // third-level fault
        send_request(52'h5_A5A5_A5A5_A5A0, 48'hAAAA_AAAA_AAAA);
        send_entry(nonlarge);
        send_entry(nonlarge);
        send_entry(64'hFFFF_FFFF_FFFF_FF7E);
        // 4 KiB page with the present bit clear at the last level
        send_request('0, '1);
        send_entry(nonlarge);
        send_entry(nonlarge);
        send_entry(nonlarge);
        send_entry(64'hFFFF_FFFF_FFFF_FFFE);
        // last-level masked entry zero
        send_request('1, '0);
        send_entry(nonlarge);
        send_entry(nonlarge);
        send_entry(nonlarge);
        send_entry(~{12'd0, PMASK});
        wait_drained();

        n_items = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        while (n_items < RANDOM_BEATS) begin
            if (n_items == 200 && !hold_done) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            if (n_items == 400 && !pause_done) begin
                pause_done = 1'b1;
                wait_drained();
            end
            if (n_items == 500) idle_on = 1'b0;
            if (n_items == 650) idle_on = 1'b1;
            r1 = {$urandom, $urandom};
            r2 = {$urandom, $urandom};
            if (walk.level == LVL_IDLE) begin
                if ($urandom_range(0, 99) < 92) begin
                    send_request(r1[ADDR_W-1:0], r2[VA_W-1:0]);
                    n_items++;
                end else begin
                    send_entry(r1);
                end
            end else begin
                if ($urandom_range(0, 99) < 94) begin
                    send_entry(random_entry(walk.level));
                    n_items++;
                end else begin
                    send_request(r1[ADDR_W-1:0], r2[VA_W-1:0]);
                end
            end
        end
        wait_drained();
        repeat (20) @(negedge aclk);

        $display("Run covered %0d input beats (%0d ignored), %0d table reads issued,",
                 walk.n_beats, walk.n_ignored, walk.n_reads);
        $display("%0d walks translated and %0d walks faulted.", walk.n_done, walk.n_faults);
        if (walk.errors == 0 && walk.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> four_level_page_table_walker.f
rtl/ptw_pkg.sv
rtl/ptw_step.sv
rtl/four_level_page_table_walker.sv
tb/testbench.sv
